### src/sdtq_pkg.sv
// Package for the sorted delay timer queue: sizes, request codes, sequencer
// states and payload structs. No dependencies.
package sdtq_pkg;

	localparam int QUEUE_SLOTS = 32;
	localparam int IDX_W = $clog2(QUEUE_SLOTS);
	localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
	localparam int TICK_W = 31;
	localparam int TASK_W = 8;
	localparam int ENTRY_W = TICK_W + TASK_W;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	// Reply codes
	localparam logic [31:0] RV_FULL = 32'hFFFF_FFFF;
	localparam logic [31:0] RV_UNKNOWN = 32'hFFFF_FFFE;
	localparam logic [31:0] RV_ZERO = 32'd0;
	localparam logic [31:0] RV_ONE = 32'd1;

	typedef enum logic [2:0] {
		FN_DELAY  = 3'd0,
		FN_TIME   = 3'd1,
		FN_TICK   = 3'd2,
		FN_CANCEL = 3'd3,
		FN_QUIT   = 3'd4
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_INS_WAIT,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_CAN_WAIT,
		ST_CAN_CMP,
		ST_SH_WAIT,
		ST_SH_CMP,
		ST_CAN_R1,
		ST_CAN_R2,
		ST_DUE_WAIT,
		ST_DUE_CMP,
		ST_SHUT_WAIT,
		ST_SHUT_CMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]        func;
		logic [TASK_W-1:0] requester;
		logic [TICK_W-1:0] target_tick;
		logic [TASK_W-1:0] cancel_task;
	} in_t;

	typedef struct packed {
		logic [TASK_W-1:0] dest_task;
		logic signed [31:0] reply_value;
		logic              last;
	} out_t;

	typedef struct packed {
		logic [TICK_W-1:0] wake;
		logic [TASK_W-1:0] task_id;
	} entry_t;

endpackage

### src/sorted_delay_timer_queue_unit.sv
// Sorted delay timer queue, top level. Uses sdtq_pkg and sdtq_ram.
//
// The block keeps a tick counter and a queue of waiting tasks in one RAM,
// sorted by wake tick, held as a ring with a head pointer. One request is
// taken at a time; a sequencer walks the RAM entry by entry (read, then
// compare and write back). A delay_until walks the entries with a later
// wake tick, a cancel the entries up to the match and behind it, and due
// entries are released one at a time from the head; a tick with shutdown
// releases every waiter. Replies leave through an output register and
// stall the sequencer only when the consumer holds off. There is no
// clearing pass after reset.
module sorted_delay_timer_queue_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sdtq_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sdtq_pkg::out_t out_data
);

	localparam int IDX_W = sdtq_pkg::IDX_W;
	localparam int CNT_W = sdtq_pkg::CNT_W;
	localparam int TICK_W = sdtq_pkg::TICK_W;
	localparam int TASK_W = sdtq_pkg::TASK_W;

	sdtq_pkg::state_t state_q, state_d;
	sdtq_pkg::in_t    item_q;
	logic [TICK_W-1:0] tick_q, tick_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              armed_q, armed_d;
	logic [TASK_W-1:0] quitter_q, quitter_d;
	logic              halted_q, halted_d;
	logic              shut_q, shut_d;

	logic              pend_v_q;
	logic [TASK_W-1:0] pend_dest_q;
	logic [31:0]       pend_val_q;
	logic              out_v_q;
	sdtq_pkg::out_t    out_q;

	logic              emit_v;
	logic [TASK_W-1:0] emit_dest;
	logic [31:0]       emit_val;
	logic              out_free, can_emit, emit_fire, flush;

	logic              ram_we;
	logic [IDX_W-1:0]  wr_log;
	sdtq_pkg::entry_t  wr_entry, rd_entry, new_entry;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;

	logic [CNT_W-1:0]  idx_next_c;
	logic              more_c;
	logic [IDX_W-1:0]  head_inc;
	logic [31:0]       tick_ext, neg_tick;

	// Logical queue position to RAM address
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
		input logic [IDX_W-1:0] i);
		logic [IDX_W:0] s;
		s = {1'b0, h} + {1'b0, i};
		if (s >= (IDX_W+1)'(sdtq_pkg::QUEUE_SLOTS)) begin
			s = s - (IDX_W+1)'(sdtq_pkg::QUEUE_SLOTS);
		end
		return s[IDX_W-1:0];
	endfunction

	assign ram_raddr = phys(head_q, idx_q);
	assign ram_waddr = phys(head_q, wr_log);

	sdtq_ram #(
		.WIDTH(sdtq_pkg::ENTRY_W),
		.DEPTH(sdtq_pkg::QUEUE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	assign in_ready  = (state_q == sdtq_pkg::ST_IDLE);
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	assign out_free  = !out_v_q || out_ready;
	assign can_emit  = !pend_v_q || out_free;
	assign emit_fire = emit_v && can_emit;

	assign idx_next_c = CNT_W'(idx_q) + CNT_W'(1);
	assign more_c     = idx_next_c < count_q;
	assign head_inc   = (head_q == IDX_W'(sdtq_pkg::QUEUE_SLOTS - 1)) ? '0 : head_q + IDX_W'(1);
	assign tick_ext   = {1'b0, tick_q};
	assign neg_tick   = 32'd0 - tick_ext;
	assign new_entry  = '{wake: item_q.target_tick, task_id: item_q.requester};

	// Sequencer: next state, RAM writes, reply generation
	always_comb begin
		state_d   = state_q;
		tick_d    = tick_q;
		count_d   = count_q;
		head_d    = head_q;
		idx_d     = idx_q;
		armed_d   = armed_q;
		quitter_d = quitter_q;
		halted_d  = halted_q;
		shut_d    = shut_q;
		emit_v    = 1'b0;
		emit_dest = item_q.requester;
		emit_val  = sdtq_pkg::RV_ZERO;
		ram_we    = 1'b0;
		wr_log    = '0;
		wr_entry  = new_entry;
		flush     = 1'b0;

		unique case (state_q)
			sdtq_pkg::ST_IDLE: begin
				shut_d = 1'b0;
				if (in_valid && !halted_q) begin
					state_d = sdtq_pkg::ST_EXEC;
				end
			end
			sdtq_pkg::ST_EXEC: begin
				idx_d = '0;
				unique case (item_q.func)
					sdtq_pkg::FN_DELAY: begin
						if (count_q == CNT_W'(sdtq_pkg::QUEUE_SLOTS)) begin
							emit_v   = 1'b1;
							emit_val = sdtq_pkg::RV_FULL;
							if (can_emit) begin
								state_d = sdtq_pkg::ST_DUE_WAIT;
							end
						end else if (count_q == '0) begin
							ram_we  = 1'b1;
							count_d = count_q + CNT_W'(1);
							state_d = sdtq_pkg::ST_DUE_WAIT;
						end else begin
							idx_d   = IDX_W'(count_q - CNT_W'(1));
							state_d = sdtq_pkg::ST_INS_WAIT;
						end
					end
					sdtq_pkg::FN_TIME: begin
						emit_v   = 1'b1;
						emit_val = tick_ext;
						if (can_emit) begin
							state_d = sdtq_pkg::ST_DUE_WAIT;
						end
					end
					sdtq_pkg::FN_TICK: begin
						emit_v   = 1'b1;
						emit_val = armed_q ? sdtq_pkg::RV_ZERO : sdtq_pkg::RV_ONE;
						if (can_emit) begin
							if (armed_q) begin
								shut_d = 1'b1;
							end else if (tick_q != sdtq_pkg::TICK_MAX) begin
								tick_d = tick_q + TICK_W'(1);
							end
							state_d = sdtq_pkg::ST_DUE_WAIT;
						end
					end
					sdtq_pkg::FN_CANCEL: begin
						if (count_q == '0) begin
							emit_v   = 1'b1;
							emit_val = sdtq_pkg::RV_ONE;
							if (can_emit) begin
								state_d = sdtq_pkg::ST_DUE_WAIT;
							end
						end else begin
							state_d = sdtq_pkg::ST_CAN_WAIT;
						end
					end
					sdtq_pkg::FN_QUIT: begin
						armed_d   = 1'b1;
						quitter_d = item_q.requester;
						state_d   = sdtq_pkg::ST_DUE_WAIT;
					end
					default: begin
						emit_v   = 1'b1;
						emit_val = sdtq_pkg::RV_UNKNOWN;
						if (can_emit) begin
							state_d = sdtq_pkg::ST_DUE_WAIT;
						end
					end
				endcase
			end
			// Insert: walk from the tail, shift later wake ticks up by one
			sdtq_pkg::ST_INS_WAIT: begin
				state_d = sdtq_pkg::ST_INS_CMP;
			end
			sdtq_pkg::ST_INS_CMP: begin
				ram_we = 1'b1;
				wr_log = idx_q + IDX_W'(1);
				if (rd_entry.wake > item_q.target_tick) begin
					wr_entry = rd_entry;
					if (idx_q == '0) begin
						state_d = sdtq_pkg::ST_INS_PUT;
					end else begin
						idx_d   = idx_q - IDX_W'(1);
						state_d = sdtq_pkg::ST_INS_WAIT;
					end
				end else begin
					count_d = count_q + CNT_W'(1);
					idx_d   = '0;
					state_d = sdtq_pkg::ST_DUE_WAIT;
				end
			end
			sdtq_pkg::ST_INS_PUT: begin
				ram_we  = 1'b1;
				count_d = count_q + CNT_W'(1);
				idx_d   = '0;
				state_d = sdtq_pkg::ST_DUE_WAIT;
			end
			// Cancel: search from the head for the task
			sdtq_pkg::ST_CAN_WAIT: begin
				state_d = sdtq_pkg::ST_CAN_CMP;
			end
			sdtq_pkg::ST_CAN_CMP: begin
				if (rd_entry.task_id == item_q.cancel_task) begin
					if (more_c) begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = sdtq_pkg::ST_SH_WAIT;
					end else begin
						count_d = count_q - CNT_W'(1);
						state_d = sdtq_pkg::ST_CAN_R1;
					end
				end else if (more_c) begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = sdtq_pkg::ST_CAN_WAIT;
				end else begin
					emit_v   = 1'b1;
					emit_val = sdtq_pkg::RV_ONE;
					if (can_emit) begin
						idx_d   = '0;
						state_d = sdtq_pkg::ST_DUE_WAIT;
					end
				end
			end
			// Close the gap behind the cancelled entry
			sdtq_pkg::ST_SH_WAIT: begin
				state_d = sdtq_pkg::ST_SH_CMP;
			end
			sdtq_pkg::ST_SH_CMP: begin
				ram_we   = 1'b1;
				wr_log   = idx_q - IDX_W'(1);
				wr_entry = rd_entry;
				if (more_c) begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = sdtq_pkg::ST_SH_WAIT;
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = sdtq_pkg::ST_CAN_R1;
				end
			end
			sdtq_pkg::ST_CAN_R1: begin
				emit_v   = 1'b1;
				emit_val = sdtq_pkg::RV_ZERO;
				if (can_emit) begin
					state_d = sdtq_pkg::ST_CAN_R2;
				end
			end
			sdtq_pkg::ST_CAN_R2: begin
				emit_v    = 1'b1;
				emit_dest = item_q.cancel_task;
				emit_val  = neg_tick;
				if (can_emit) begin
					idx_d   = '0;
					state_d = sdtq_pkg::ST_DUE_WAIT;
				end
			end
			// Release due entries from the head
			sdtq_pkg::ST_DUE_WAIT: begin
				state_d = sdtq_pkg::ST_DUE_CMP;
			end
			sdtq_pkg::ST_DUE_CMP: begin
				if (count_q != '0 && rd_entry.wake <= tick_q) begin
					emit_v    = 1'b1;
					emit_dest = rd_entry.task_id;
					emit_val  = tick_ext;
					if (can_emit) begin
						head_d  = head_inc;
						count_d = count_q - CNT_W'(1);
						state_d = sdtq_pkg::ST_DUE_WAIT;
					end
				end else if (shut_q) begin
					state_d = sdtq_pkg::ST_SHUT_WAIT;
				end else begin
					state_d = sdtq_pkg::ST_FIN;
				end
			end
			// Shutdown: release all waiters, then the quitter
			sdtq_pkg::ST_SHUT_WAIT: begin
				state_d = sdtq_pkg::ST_SHUT_CMP;
			end
			sdtq_pkg::ST_SHUT_CMP: begin
				emit_v   = 1'b1;
				emit_val = tick_ext;
				if (count_q != '0) begin
					emit_dest = rd_entry.task_id;
					if (can_emit) begin
						head_d  = head_inc;
						count_d = count_q - CNT_W'(1);
						state_d = sdtq_pkg::ST_SHUT_WAIT;
					end
				end else begin
					emit_dest = quitter_q;
					if (can_emit) begin
						halted_d = 1'b1;
						state_d  = sdtq_pkg::ST_FIN;
					end
				end
			end
			// Send the held reply marked as the last one
			sdtq_pkg::ST_FIN: begin
				if (!pend_v_q) begin
					state_d = sdtq_pkg::ST_IDLE;
				end else if (out_free) begin
					flush   = 1'b1;
					state_d = sdtq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdtq_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sdtq_pkg::ST_IDLE;
			tick_q    <= '0;
			count_q   <= '0;
			head_q    <= '0;
			idx_q     <= '0;
			armed_q   <= 1'b0;
			quitter_q <= '0;
			halted_q  <= 1'b0;
			shut_q    <= 1'b0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			tick_q    <= tick_d;
			count_q   <= count_d;
			head_q    <= head_d;
			idx_q     <= idx_d;
			armed_q   <= armed_d;
			quitter_q <= quitter_d;
			halted_q  <= halted_d;
			shut_q    <= shut_d;
			if (emit_fire) begin
				pend_v_q <= 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
			end
			if ((emit_fire && pend_v_q) || flush) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers: captured request, held reply, output register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (emit_fire) begin
			pend_dest_q <= emit_dest;
			pend_val_q  <= emit_val;
		end
		if ((emit_fire && pend_v_q) || flush) begin
			out_q.dest_task   <= pend_dest_q;
			out_q.reply_value <= pend_val_q;
			out_q.last        <= flush;
		end
	end

endmodule

### src/sdtq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module sdtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
